// File: hdl/bdqs_pkg.sv
// ============================================================================
// bdqs_pkg
// Shared constants, codes and types for the bounded deque with search.
// ============================================================================
`default_nettype none

package bdqs_pkg;

    // Number of slots in the cell chain.
    localparam int CAPACITY = 16;

    // Internal count width: holds 0 .. CAPACITY.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed widths of the word fields.
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_REMOVE     = 3'd4,
        FUNC_SEARCH     = 3'd5
    } func_t;

    // Action broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        ACT_HOLD,         // keep stored value
        ACT_SHIFT_RIGHT,  // take value from front-side neighbor
        ACT_LOAD_TAIL,    // tail cell loads the key
        ACT_SHIFT_LEFT,   // take value from back-side neighbor
        ACT_CLOSE_MATCH   // cells at or behind the first match shift left
    } act_t;

    // Per-cell control bundle.
    typedef struct packed {
        act_t act;
        logic valid;  // cell holds a live entry
        logic tail;   // cell is the first free slot
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/bdqs_if.sv
// ============================================================================
// bdqs_if
// Valid/ready channels for request and response words.
// ============================================================================
`default_nettype none

// Request channel: one operation word.
interface bdqs_req_if;
    logic                             valid;
    logic                             ready;
    logic [bdqs_pkg::FUNC_W-1:0]      func;
    logic signed [bdqs_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// Response channel: one result word.
interface bdqs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [bdqs_pkg::COUNT_W-1:0] count;

    modport source (output valid, output ok, output count, input ready);
    modport sink   (input valid, input ok, input count, output ready);
endinterface

`default_nettype wire

// File: hdl/bdqs_cell.sv
// ============================================================================
// bdqs_cell
// One slot of the deque: stored value, key compare and neighbor shift.
// ============================================================================
`default_nettype none

module bdqs_cell (
    input  wire                                  clk,
    input  wire bdqs_pkg::cell_ctl_t             ctl,
    input  wire logic signed [bdqs_pkg::VALUE_W-1:0] key,
    input  wire logic signed [bdqs_pkg::VALUE_W-1:0] left_val,
    input  wire logic signed [bdqs_pkg::VALUE_W-1:0] right_val,
    input  wire logic                            match_in,
    output logic                                 match_out,
    output logic signed [bdqs_pkg::VALUE_W-1:0]  val
);

    logic signed [bdqs_pkg::VALUE_W-1:0] val_reg;
    logic signed [bdqs_pkg::VALUE_W-1:0] val_next;
    logic                                hit;

    // Match on live entries only; prefix OR runs down the chain
    assign hit       = ctl.valid && (val_reg == key);
    assign match_out = match_in | hit;
    assign val       = val_reg;

    // Next value select
    always_comb
    begin
        unique case (ctl.act)
            bdqs_pkg::ACT_HOLD:        val_next = val_reg;
            bdqs_pkg::ACT_SHIFT_RIGHT: val_next = left_val;
            bdqs_pkg::ACT_LOAD_TAIL:   val_next = ctl.tail ? key : val_reg;
            bdqs_pkg::ACT_SHIFT_LEFT:  val_next = right_val;
            bdqs_pkg::ACT_CLOSE_MATCH: val_next = match_out ? right_val : val_reg;
            default:                   val_next = val_reg;
        endcase
    end

    // Slot storage (payload, no reset)
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// File: hdl/bounded_deque_with_search_unit.sv
// ============================================================================
// bounded_deque_with_search_unit
// Fixed-capacity deque of signed 32-bit values built as a chain of cells.
// ============================================================================
// Usage:
//   req carries one operation word (func, value); rsp returns one result
//   word (ok, count) for every request word, in order.
//   Each cell holds one slot, compares it against the key and loads from
//   its front or back neighbor, so every operation, remove-by-value and
//   search included, completes in the cycle the word is accepted.
//   The result is registered and is on rsp in the cycle after acceptance.
//   Throughput: one word per cycle while the receiver takes results; the
//   depth of the cell chain (compare plus the first-match prefix chain) sets the cycle time.
//   A single output register holds the result; req stays ready while that
//   register is empty or is being emptied in the same cycle, so a stalled
//   receiver holds back at most one result and then stops requests.
//   Reset empties the deque (count zero) and drops any pending result.
//   Slot contents are not cleared; slots past the count are never read.
// ============================================================================
`default_nettype none

module bounded_deque_with_search_unit (
    input  wire         clk,
    input  wire         rst_n,
    bdqs_req_if.sink    req,
    bdqs_rsp_if.source  rsp
);

    localparam int CAP = bdqs_pkg::CAPACITY;
    localparam int CW  = bdqs_pkg::CNT_W;
    localparam int VW  = bdqs_pkg::VALUE_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_ok_reg;
    logic [CW-1:0] rsp_count_reg;
    logic          ok_next;
    logic          accept;
    logic          full;
    logic          empty;
    logic          any_hit;
    bdqs_pkg::act_t act;

    logic signed [VW-1:0] cell_val [CAP];
    logic                 match    [CAP+1];
    logic [CW+bdqs_pkg::COUNT_W-1:0] count_ext;

    // Handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full    = (count_reg == CW'(CAP));
    assign empty   = (count_reg == '0);
    assign match[0] = 1'b0;
    assign any_hit = match[CAP];

    // Operation decode
    always_comb
    begin
        act        = bdqs_pkg::ACT_HOLD;
        ok_next    = 1'b0;
        count_next = count_reg;
        unique case (req.func)
            bdqs_pkg::FUNC_PUSH_FRONT:
            begin
                if (!full)
                begin
                    act        = bdqs_pkg::ACT_SHIFT_RIGHT;
                    ok_next    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdqs_pkg::FUNC_PUSH_BACK:
            begin
                if (!full)
                begin
                    act        = bdqs_pkg::ACT_LOAD_TAIL;
                    ok_next    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdqs_pkg::FUNC_POP_FRONT:
            begin
                if (!empty)
                begin
                    act        = bdqs_pkg::ACT_SHIFT_LEFT;
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            bdqs_pkg::FUNC_POP_BACK:
            begin
                if (!empty)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            bdqs_pkg::FUNC_REMOVE:
            begin
                if (any_hit)
                begin
                    act        = bdqs_pkg::ACT_CLOSE_MATCH;
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            bdqs_pkg::FUNC_SEARCH:
            begin
                ok_next = any_hit;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (!accept)
        begin
            act = bdqs_pkg::ACT_HOLD;
        end
    end

    // Cell chain
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        bdqs_pkg::cell_ctl_t  ctl;
        logic signed [VW-1:0] left_val;
        logic signed [VW-1:0] right_val;

        // act, live-entry flag, first-free-slot flag
        assign ctl = {act, (count_reg > CW'(i)), (count_reg == CW'(i))};

        if (i == 0)
        begin : g_head
            assign left_val = req.value;
        end
        else
        begin : g_body
            assign left_val = cell_val[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_inner
            assign right_val = cell_val[i+1];
        end

        bdqs_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .key       (req.value),
            .left_val  (left_val),
            .right_val (right_val),
            .match_in  (match[i]),
            .match_out (match[i+1]),
            .val       (cell_val[i])
        );
    end

    // Entry count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_ok_reg    <= ok_next;
            rsp_count_reg <= count_next;
        end
    end

    // Count output keeps the low five bits
    assign count_ext = {{bdqs_pkg::COUNT_W{1'b0}}, rsp_count_reg};
    assign rsp.valid = rsp_valid_reg;
    assign rsp.ok    = rsp_ok_reg;
    assign rsp.count = count_ext[bdqs_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

// File: dv/tb_bounded_deque_with_search_unit.sv
// ============================================================================
// tb_bounded_deque_with_search_unit
// Drives operation words into the deque with random idle gaps on both
// channels, predicts ok and count for each accepted word against a shadow
// copy of the slots, and checks every result word in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_bounded_deque_with_search_unit;

    // Codes outside the operation set; the block must treat them as no-ops.
    localparam logic [bdqs_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [bdqs_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    // Sender / receiver idle styles.
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_FULL   = 1;
    localparam int IDLE_SPARSE = 2;

    // Random stream biases.
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    localparam int PHASE_WORDS = 50;
    localparam int PHASES      = 14;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow deque plus queues of expected result fields.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [bdqs_pkg::VALUE_W-1:0] shadow_slots[$];
        logic                         expected_ok[$];
        logic [bdqs_pkg::COUNT_W-1:0] expected_count[$];
        string                        faults[$];
        int                           words_checked;

        function int pending();
            return expected_ok.size();
        endfunction

        // Apply one accepted request word to the shadow and queue its result.
        function void note_request(logic [bdqs_pkg::FUNC_W-1:0] f,
                                   logic [bdqs_pkg::VALUE_W-1:0] v);
            int  i;
            int  first_hit;
            logic done_ok;
            first_hit = -1;
            done_ok   = 1'b0;
            for (i = 0; i < shadow_slots.size(); i++)
            begin
                if (first_hit < 0 && shadow_slots[i] === v)
                    first_hit = i;
            end
            case (f)
                bdqs_pkg::FUNC_PUSH_FRONT:
                    if (shadow_slots.size() < bdqs_pkg::CAPACITY)
                    begin
                        shadow_slots.push_front(v);
                        done_ok = 1'b1;
                    end
                bdqs_pkg::FUNC_PUSH_BACK:
                    if (shadow_slots.size() < bdqs_pkg::CAPACITY)
                    begin
                        shadow_slots.push_back(v);
                        done_ok = 1'b1;
                    end
                bdqs_pkg::FUNC_POP_FRONT:
                    if (shadow_slots.size() > 0)
                    begin
                        void'(shadow_slots.pop_front());
                        done_ok = 1'b1;
                    end
                bdqs_pkg::FUNC_POP_BACK:
                    if (shadow_slots.size() > 0)
                    begin
                        void'(shadow_slots.pop_back());
                        done_ok = 1'b1;
                    end
                bdqs_pkg::FUNC_REMOVE:
                    if (first_hit >= 0)
                    begin
                        shadow_slots.delete(first_hit);
                        done_ok = 1'b1;
                    end
                bdqs_pkg::FUNC_SEARCH:
                    done_ok = (first_hit >= 0);
                default:
                    done_ok = 1'b0;
            endcase
            expected_ok.push_back(done_ok);
            expected_count.push_back(bdqs_pkg::COUNT_W'(shadow_slots.size()));
        endfunction

        // Compare one result word against the oldest expectation.
        function void check_result(logic ok, logic [bdqs_pkg::COUNT_W-1:0] cnt);
            logic                         want_ok;
            logic [bdqs_pkg::COUNT_W-1:0] want_cnt;
            if (expected_ok.size() == 0)
            begin
                faults.push_back($sformatf("result ok=%b count=%0d with nothing pending",
                                           ok, cnt));
                return;
            end
            want_ok  = expected_ok.pop_front();
            want_cnt = expected_count.pop_front();
            if (ok !== want_ok)
                faults.push_back($sformatf("word %0d: ok=%b, want %b",
                                           words_checked, ok, want_ok));
            if (cnt !== want_cnt)
                faults.push_back($sformatf("word %0d: count=%0d, want %0d",
                                           words_checked, cnt, want_cnt));
            words_checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   err_cnt;
    int   snd_mode;
    int   rcv_mode;
    logic [bdqs_pkg::VALUE_W-1:0] value_pool[8];

    deque_scoreboard sb = new();

    bdqs_req_if req_ch();
    bdqs_rsp_if rsp_ch();

    bounded_deque_with_search_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(string msg);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int draw_gap(int mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_FULL:   return $urandom_range(0, 17);
            default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    // Send one word; valid stays high afterwards unless the next word idles.
    task automatic send_word(logic [bdqs_pkg::FUNC_W-1:0] f,
                             logic [bdqs_pkg::VALUE_W-1:0] v);
        int gap;
        gap = draw_gap(snd_mode);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(f, v);
    endtask

    // Pool values hit often; held values make remove/search find matches.
    function automatic logic [bdqs_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return value_pool[$urandom_range(0, 7)];
        if (r < 80 && sb.shadow_slots.size() > 0)
            return sb.shadow_slots[$urandom_range(0, sb.shadow_slots.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [bdqs_pkg::FUNC_W-1:0] pick_func(int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            BIAS_FILL:
            begin
                if (r < 40) return bdqs_pkg::FUNC_PUSH_FRONT;
                if (r < 80) return bdqs_pkg::FUNC_PUSH_BACK;
                if (r < 88) return bdqs_pkg::FUNC_SEARCH;
                if (r < 94) return bdqs_pkg::FUNC_REMOVE;
                if (r < 97)
                    return (r[0]) ? bdqs_pkg::FUNC_POP_FRONT : bdqs_pkg::FUNC_POP_BACK;
            end
            BIAS_DRAIN:
            begin
                if (r < 10)
                    return (r[0]) ? bdqs_pkg::FUNC_PUSH_FRONT : bdqs_pkg::FUNC_PUSH_BACK;
                if (r < 35) return bdqs_pkg::FUNC_POP_FRONT;
                if (r < 60) return bdqs_pkg::FUNC_POP_BACK;
                if (r < 85) return bdqs_pkg::FUNC_REMOVE;
                if (r < 97) return bdqs_pkg::FUNC_SEARCH;
            end
            default:
            begin
                if (r < 16) return bdqs_pkg::FUNC_PUSH_FRONT;
                if (r < 32) return bdqs_pkg::FUNC_PUSH_BACK;
                if (r < 48) return bdqs_pkg::FUNC_POP_FRONT;
                if (r < 64) return bdqs_pkg::FUNC_POP_BACK;
                if (r < 80) return bdqs_pkg::FUNC_REMOVE;
                if (r < 97) return bdqs_pkg::FUNC_SEARCH;
            end
        endcase
        return (r[0]) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    endfunction

    // Receiver: random stalls, check each word as it is taken.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(rcv_mode);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            sb.check_result(rsp_ch.ok, rsp_ch.count);
            while (sb.faults.size() > 0)
                report(sb.faults.pop_front());
        end
    end

    // Main sequence
    initial
    begin
        int phase;
        int n;
        int bias;
        err_cnt      = 0;
        snd_mode     = IDLE_SPARSE;
        rcv_mode     = IDLE_SPARSE;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (n = 4; n < 8; n++)
            value_pool[n] = $urandom();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store refusals, spare codes, extremes, duplicates
        send_word(bdqs_pkg::FUNC_POP_FRONT,  32'h0);
        send_word(bdqs_pkg::FUNC_POP_BACK,   32'h0);
        send_word(bdqs_pkg::FUNC_REMOVE,     32'h0);
        send_word(bdqs_pkg::FUNC_SEARCH,     32'h0);
        send_word(FUNC_SPARE_6,              32'h0);
        send_word(FUNC_SPARE_7,              32'h7FFF_FFFF);
        send_word(bdqs_pkg::FUNC_PUSH_FRONT, 32'h8000_0000);
        send_word(bdqs_pkg::FUNC_PUSH_BACK,  32'h7FFF_FFFF);
        send_word(bdqs_pkg::FUNC_PUSH_BACK,  32'hFFFF_FFFF);
        send_word(bdqs_pkg::FUNC_PUSH_FRONT, 32'h0);
        send_word(bdqs_pkg::FUNC_PUSH_BACK,  32'hFFFF_FFFF);
        send_word(bdqs_pkg::FUNC_SEARCH,     32'h8000_0000);
        send_word(bdqs_pkg::FUNC_SEARCH,     32'h0000_0001);
        send_word(bdqs_pkg::FUNC_REMOVE,     32'hFFFF_FFFF);  // first of two copies
        send_word(bdqs_pkg::FUNC_REMOVE,     32'h0000_3039);  // no match
        send_word(FUNC_SPARE_6,              32'hFFFF_FFFF);  // no-op on a live store
        send_word(bdqs_pkg::FUNC_POP_FRONT,  32'h0);
        send_word(bdqs_pkg::FUNC_POP_BACK,   32'h0);
        send_word(bdqs_pkg::FUNC_SEARCH,     32'hFFFF_FFFF);
        send_word(bdqs_pkg::FUNC_POP_BACK,   32'h0);
        send_word(bdqs_pkg::FUNC_POP_FRONT,  32'h0);
        send_word(bdqs_pkg::FUNC_POP_BACK,   32'h0);

        // Random phases: fill toward full, drain toward empty, or mix
        for (phase = 0; phase < PHASES; phase++)
        begin
            bias     = (phase == 0) ? BIAS_FILL : $urandom_range(0, 2);
            snd_mode = $urandom_range(0, 2);
            rcv_mode = $urandom_range(0, 2);
            for (n = 0; n < PHASE_WORDS; n++)
                send_word(pick_func(bias), pick_value());
        end

        // Drain, then let any stray word show up
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_cnt == 0)
            $display("tb_bounded_deque_with_search_unit: clean");
        else
            $display("tb_bounded_deque_with_search_unit: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("tb_bounded_deque_with_search_unit: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/bdqs_pkg.sv
hdl/bdqs_if.sv
hdl/bdqs_cell.sv
hdl/bounded_deque_with_search_unit.sv
dv/tb_bounded_deque_with_search_unit.sv
